FILE: rtl/stpc_pkg.sv
// Shared types and constants for the super-twisting position controller.
package stpc_pkg;

  // Internal working width: holds every exact intermediate for value widths up to 48 bits
  localparam int XW        = 68;
  // Gain operand width and its fraction bits (Q8.8)
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 8;
  localparam int RATE_W    = 12;
  // Intermediates are bounded at +-2^CAP_SHIFT
  localparam int CAP_SHIFT = 61;
  // Radicand bit span before the fraction shift
  localparam int RAD_BITS  = 64;
  // Fraction bits of the k2*dt product (Q8.8 times Q0.16)
  localparam int K2DT_FRAC = 24;
  // Configuration port
  localparam int ADDR_W    = 5;
  localparam int REG_W     = 32;

  localparam logic [1:0] AXIS_Z = 2'd2;

  // Register reset values
  localparam logic [GAIN_W-1:0] RST_SLOPE_H  = 16'd192;
  localparam logic [GAIN_W-1:0] RST_SLOPE_V  = 16'd256;
  localparam logic [GAIN_W-1:0] RST_ROOT_H   = 16'd256;
  localparam logic [GAIN_W-1:0] RST_ROOT_V   = 16'd256;
  localparam logic [GAIN_W-1:0] RST_TWIST_H  = 16'd77;
  localparam logic [GAIN_W-1:0] RST_TWIST_V  = 16'd384;
  localparam logic [GAIN_W-1:0] RST_PERIOD   = 16'd1311;
  localparam logic [RATE_W-1:0] RST_RATE     = 12'd50;

  typedef enum logic [2:0] {
    REG_SLOPE_H,
    REG_SLOPE_V,
    REG_ROOT_H,
    REG_ROOT_V,
    REG_TWIST_H,
    REG_TWIST_V,
    REG_TICK_PERIOD,
    REG_TICK_RATE
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] slope_h;
    logic [GAIN_W-1:0] slope_v;
    logic [GAIN_W-1:0] root_h;
    logic [GAIN_W-1:0] root_v;
    logic [GAIN_W-1:0] twist_h;
    logic [GAIN_W-1:0] twist_v;
    logic [GAIN_W-1:0] tick_period;
    logic [RATE_W-1:0] tick_rate;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VS,
    ST_DDOT,
    ST_E1,
    ST_E2,
    ST_S,
    ST_ROOT,
    ST_RT,
    ST_KP,
    ST_KR,
    ST_TI,
    ST_A1,
    ST_A2,
    ST_A3,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/stpc_cfg_regs.sv
// Configuration register file behind the APB-style port.
module stpc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [stpc_pkg::ADDR_W-1:0] paddr,
  input  logic [stpc_pkg::REG_W-1:0]  pwdata,
  output logic [stpc_pkg::REG_W-1:0]  prdata,
  output logic                        pready,
  output stpc_pkg::cfg_t              cfg
);
  import stpc_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slope_h     <= RST_SLOPE_H;
      cfg.slope_v     <= RST_SLOPE_V;
      cfg.root_h      <= RST_ROOT_H;
      cfg.root_v      <= RST_ROOT_V;
      cfg.twist_h     <= RST_TWIST_H;
      cfg.twist_v     <= RST_TWIST_V;
      cfg.tick_period <= RST_PERIOD;
      cfg.tick_rate   <= RST_RATE;
    end else if (wr) begin
      case (idx)
        REG_SLOPE_H:     cfg.slope_h     <= pwdata[GAIN_W-1:0];
        REG_SLOPE_V:     cfg.slope_v     <= pwdata[GAIN_W-1:0];
        REG_ROOT_H:      cfg.root_h      <= pwdata[GAIN_W-1:0];
        REG_ROOT_V:      cfg.root_v      <= pwdata[GAIN_W-1:0];
        REG_TWIST_H:     cfg.twist_h     <= pwdata[GAIN_W-1:0];
        REG_TWIST_V:     cfg.twist_v     <= pwdata[GAIN_W-1:0];
        REG_TICK_PERIOD: cfg.tick_period <= pwdata[GAIN_W-1:0];
        REG_TICK_RATE:   cfg.tick_rate   <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (idx)
      REG_SLOPE_H:     prdata = REG_W'(cfg.slope_h);
      REG_SLOPE_V:     prdata = REG_W'(cfg.slope_v);
      REG_ROOT_H:      prdata = REG_W'(cfg.root_h);
      REG_ROOT_V:      prdata = REG_W'(cfg.root_v);
      REG_TWIST_H:     prdata = REG_W'(cfg.twist_h);
      REG_TWIST_V:     prdata = REG_W'(cfg.twist_v);
      REG_TICK_PERIOD: prdata = REG_W'(cfg.tick_period);
      REG_TICK_RATE:   prdata = REG_W'(cfg.tick_rate);
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: rtl/stpc_serial_mul.sv
// Bit-serial shift-add multiplier: signed multiplicand times unsigned gain, one gain bit a cycle.
module stpc_serial_mul (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [stpc_pkg::XW-1:0]   mcand,
  input  logic [stpc_pkg::GAIN_W-1:0]      mplier,
  output logic                             done,
  output logic signed [stpc_pkg::XW-1:0]   prod
);
  import stpc_pkg::*;

  localparam int CW = $clog2(GAIN_W);
  localparam logic [CW-1:0] LAST = CW'(GAIN_W - 1);

  logic signed [XW-1:0] acc;
  logic signed [XW-1:0] shf;
  logic [GAIN_W-1:0]    bits;
  logic [CW-1:0]        cnt;
  logic                 busy;

  assign prod = acc;

  // Add the shifted multiplicand for each set gain bit, LSB first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc  <= '0;
        shf  <= mcand;
        bits <= mplier;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (bits[0]) begin
          acc <= acc + shf;
        end
        shf  <= shf <<< 1;
        bits <= bits >> 1;
        cnt  <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/stpc_serial_sqrt.sv
// Digit-serial restoring square root, two radicand bits per cycle.
module stpc_serial_sqrt #(
  parameter int FRAC = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [stpc_pkg::XW-1:0]           rad,
  output logic                              done,
  output logic [(stpc_pkg::RAD_BITS+FRAC+1)/2-1:0] root
);
  import stpc_pkg::*;

  localparam int RW   = (RAD_BITS + FRAC + 1) / 2;
  localparam int TOPW = 2 * RW;
  localparam int CW   = $clog2(RW);
  localparam logic [CW-1:0] LAST = CW'(RW - 1);

  logic [TOPW-1:0] xsh;
  logic [RW+1:0]   rem;
  logic [RW-1:0]   r;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic [RW+3:0]   trial;
  logic [RW+3:0]   tst;
  logic [RW+3:0]   diff;
  logic            ge;

  assign root  = r;
  assign trial = {rem, xsh[TOPW-1 -: 2]};
  assign tst   = (RW+4)'({r, 2'b01});
  assign diff  = trial - tst;
  assign ge    = trial >= tst;

  // Bring down two bits, try to subtract, shift in one root bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        xsh  <= {rad[TOPW-FRAC-1:0], {FRAC{1'b0}}};
        rem  <= '0;
        r    <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[RW+1:0] : trial[RW+1:0];
        r   <= {r[RW-2:0], ge};
        xsh <= xsh << 2;
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/super_twisting_position_control.sv
// Three-axis super-twisting sliding-mode position controller, top level.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------------------------
//  s_*      | in        | s_tvalid / s_tready       | s_tdata: 12 setpoint/measurement words
//  m_*      | out       | m_tvalid / m_tready       | m_tdata: 3 commands, m_tuser: fault
//  apb      | in/out    | psel, penable, pready     | paddr, pwdata, prdata: 8 config registers
//
// Per axis a tick runs four 16-step serial multiplies, a fifth one when the
// velocity setpoint is derived from position, a (64+FRACTION_BITS+1)/2-step
// square root (Q16.16 by default) and the register steps S, KP, KR, TI and
// A1 to A3. One tick is in flight at a time; s_tready is high only when idle.
// A finished result waits in the output register and a new beat is taken
// meanwhile. No clearing pass after reset: control state and the kept ppt,
// pvt and ti clear at once.
module super_twisting_position_control #(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // meas_pos_x,y,z, meas_vel_x,y,z, target_pos_x,y,z, target_vel_x,y,z (LSB first)
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [((12*VALUE_WIDTH+7)/8)*8-1:0]     s_tdata,
  // accel_cmd_x, accel_cmd_y, accel_cmd_z (LSB first)
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [((3*VALUE_WIDTH+7)/8)*8-1:0]      m_tdata,
  // overflow_fault
  output logic [0:0]                              m_tuser,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [stpc_pkg::ADDR_W-1:0]             paddr,
  input  logic [stpc_pkg::REG_W-1:0]              pwdata,
  output logic [stpc_pkg::REG_W-1:0]              prdata,
  output logic                                    pready
);
  import stpc_pkg::*;

  localparam int W      = VALUE_WIDTH;
  localparam int F      = FRACTION_BITS;
  localparam int MD_W   = ((3*W+7)/8)*8;
  localparam int ROOT_W = (RAD_BITS + F + 1) / 2;
  localparam int KSH    = K2DT_FRAC - F;

  localparam logic signed [XW-1:0] VMAX_X  = (XW'(1) <<< (W-1)) - XW'(1);
  localparam logic signed [XW-1:0] VMIN_X  = -VMAX_X - XW'(1);
  localparam logic signed [XW-1:0] CAP_X   = XW'(1) <<< CAP_SHIFT;
  localparam logic signed [XW-1:0] RND_POS = XW'(1) <<< (GAIN_FRAC-1);
  localparam logic signed [XW-1:0] RND_NEG = RND_POS - XW'(1);
  localparam logic [32:0]          KHALF   = (33'd1 << KSH) >> 1;
  localparam logic [W-1:0]         VMIN_W  = {1'b1, {(W-1){1'b0}}};

  // Round a Q8.8-gain product to nearest, ties away from zero
  function automatic logic signed [XW-1:0] rnd8(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] t;
    t = v + (v[XW-1] ? RND_NEG : RND_POS);
    return t >>> GAIN_FRAC;
  endfunction

  function automatic logic over_cap(input logic signed [XW-1:0] v);
    return (v > CAP_X) || (v < -CAP_X);
  endfunction

  function automatic logic signed [W-1:0] clampw(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] t;
    t = (v > VMAX_X) ? VMAX_X : ((v < VMIN_X) ? VMIN_X : v);
    return t[W-1:0];
  endfunction

  cfg_t   cfg;
  state_t state, state_next;

  // Latched tick inputs and kept state
  logic signed [W-1:0] pos_q [3];
  logic signed [W-1:0] vel_q [3];
  logic signed [W-1:0] tp_q  [3];
  logic signed [W-1:0] tv_q  [3];
  logic signed [W-1:0] ppt   [3];
  logic signed [W-1:0] pvt   [3];
  logic signed [W-1:0] ti    [3];
  logic [W-1:0]        u_q   [3];

  logic [1:0]           ax;
  logic                 fb_q, fault_q, issued, issued_next;
  logic                 fb_in, unpub, allzero;
  logic signed [W-1:0]  vs_q;
  logic signed [XW-1:0] ddot_q, g1_q, g2_q, rt_q, s_q, acc_q;
  logic [31:0]          kprod_q;
  logic [32:0]          kdt_q;

  logic signed [W-1:0]  cur_pos, cur_vel, cur_tp, cur_tv, cur_ppt, cur_pvt, cur_ti;
  logic [GAIN_W-1:0]    c1, k1, k2, rate16;
  logic signed [XW-1:0] e1x, e2x, dpx, dvx, kdt_x, kterm, rterm, tsum, fin, s_sum, a1, a2;
  logic signed [XW-1:0] mcand, prod;
  logic [GAIN_W-1:0]    mplier;
  logic                 mul_start, mul_done, sqrt_start, sqrt_done;
  logic                 sg_pos, sg_neg, out_free;
  logic [XW-1:0]        ms;
  logic [ROOT_W-1:0]    root;

  stpc_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  stpc_serial_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (mcand),
    .mplier (mplier),
    .done   (mul_done),
    .prod   (prod)
  );

  stpc_serial_sqrt #(.FRAC(F)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .rad   (ms),
    .done  (sqrt_done),
    .root  (root)
  );

  // Velocity fallback test on the incoming beat
  always_comb begin
    unpub   = 1'b0;
    allzero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (s_tdata[(9+i)*W +: W] == VMIN_W) unpub = 1'b1;
      if (s_tdata[(9+i)*W +: W] != '0) allzero = 1'b0;
    end
    fb_in = unpub || allzero;
  end

  // Select the current axis
  assign cur_pos = pos_q[ax];
  assign cur_vel = vel_q[ax];
  assign cur_tp  = tp_q[ax];
  assign cur_tv  = tv_q[ax];
  assign cur_ppt = ppt[ax];
  assign cur_pvt = pvt[ax];
  assign cur_ti  = ti[ax];
  assign c1      = (ax == AXIS_Z) ? cfg.slope_v : cfg.slope_h;
  assign k1      = (ax == AXIS_Z) ? cfg.root_v  : cfg.root_h;
  assign k2      = (ax == AXIS_Z) ? cfg.twist_v : cfg.twist_h;
  assign rate16  = GAIN_W'(cfg.tick_rate);

  // Axis error terms and sums
  assign e1x    = XW'(cur_pos) - XW'(cur_tp);
  assign e2x    = XW'(cur_vel) - XW'(vs_q);
  assign dpx    = XW'(cur_tp) - XW'(cur_ppt);
  assign dvx    = XW'(vs_q) - XW'(cur_pvt);
  assign s_sum  = g1_q + e2x;
  assign sg_neg = s_q[XW-1];
  assign sg_pos = !s_q[XW-1] && (s_q != '0);
  assign ms     = sg_neg ? XW'(-s_q) : XW'(s_q);
  assign kdt_x  = $signed(XW'(kdt_q));
  assign kterm  = sg_pos ? kdt_x : (sg_neg ? -kdt_x : '0);
  assign tsum   = XW'(cur_ti) + kterm;
  assign rterm  = sg_pos ? rt_q : (sg_neg ? -rt_q : '0);
  assign a1     = ddot_q - g2_q;
  assign a2     = acc_q - rterm;
  assign fin    = acc_q - XW'(cur_ti);
  assign out_free = !m_tvalid || m_tready;

  // Pick multiplier operands by step
  always_comb begin
    case (state)
      ST_VS: begin
        mcand  = dpx;
        mplier = rate16;
      end
      ST_DDOT: begin
        mcand  = dvx;
        mplier = rate16;
      end
      ST_E1: begin
        mcand  = e1x;
        mplier = c1;
      end
      ST_E2: begin
        mcand  = e2x;
        mplier = c1;
      end
      ST_RT: begin
        mcand  = $signed(XW'(root));
        mplier = k1;
      end
      default: begin
        mcand  = '0;
        mplier = '0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_VS;
      ST_VS:   if (!fb_q || mul_done) state_next = ST_DDOT;
      ST_DDOT: if (mul_done) state_next = ST_E1;
      ST_E1:   if (mul_done) state_next = ST_E2;
      ST_E2:   if (mul_done) state_next = ST_S;
      ST_S:    state_next = ST_ROOT;
      ST_ROOT: if (sqrt_done) state_next = ST_RT;
      ST_RT:   if (mul_done) state_next = ST_KP;
      ST_KP:   state_next = ST_KR;
      ST_KR:   state_next = ST_TI;
      ST_TI:   state_next = ST_A1;
      ST_A1:   state_next = ST_A2;
      ST_A2:   state_next = ST_A3;
      ST_A3:   state_next = (ax == AXIS_Z) ? ST_DONE : ST_VS;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake and unit launch
  always_comb begin
    s_tready   = 1'b0;
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    case (state)
      ST_IDLE: s_tready   = 1'b1;
      ST_VS:   mul_start  = fb_q && !issued;
      ST_DDOT: mul_start  = !issued;
      ST_E1:   mul_start  = !issued;
      ST_E2:   mul_start  = !issued;
      ST_RT:   mul_start  = !issued;
      ST_ROOT: sqrt_start = !issued;
      default: ;
    endcase
  end

  assign issued_next = (issued || mul_start || sqrt_start) && !(mul_done || sqrt_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      issued <= 1'b0;
    end else begin
      state  <= state_next;
      issued <= issued_next;
    end
  end

  // Datapath: capture each step's result
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        ppt[i] <= '0;
        pvt[i] <= '0;
        ti[i]  <= '0;
      end
      m_tvalid <= 1'b0;
      fault_q  <= 1'b0;
      fb_q     <= 1'b0;
      ax       <= '0;
    end else begin
      if (m_tvalid && m_tready && state != ST_DONE) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            for (int i = 0; i < 3; i++) begin
              pos_q[i] <= s_tdata[i*W +: W];
              vel_q[i] <= s_tdata[(3+i)*W +: W];
              tp_q[i]  <= s_tdata[(6+i)*W +: W];
              tv_q[i]  <= s_tdata[(9+i)*W +: W];
            end
            fb_q    <= fb_in;
            fault_q <= 1'b0;
            ax      <= '0;
          end
        end
        ST_VS: begin
          if (!fb_q) vs_q <= cur_tv;
          else if (mul_done) vs_q <= clampw(prod);
        end
        ST_DDOT: if (mul_done) ddot_q <= prod;
        ST_E1: begin
          if (mul_done) begin
            g1_q <= rnd8(prod);
            if (over_cap(prod)) fault_q <= 1'b1;
          end
        end
        ST_E2: begin
          if (mul_done) begin
            g2_q <= rnd8(prod);
            if (over_cap(prod)) fault_q <= 1'b1;
          end
        end
        ST_S: begin
          s_q <= s_sum;
          if (over_cap(s_sum)) fault_q <= 1'b1;
        end
        ST_RT: begin
          if (mul_done) begin
            rt_q <= rnd8(prod);
            if (over_cap(prod)) fault_q <= 1'b1;
          end
        end
        ST_KP: kprod_q <= 32'(k2) * 32'(cfg.tick_period);
        ST_KR: kdt_q <= (33'(kprod_q) + KHALF) >> KSH;
        ST_TI: ti[ax] <= clampw(tsum);
        ST_A1: begin
          acc_q <= a1;
          if (over_cap(a1)) fault_q <= 1'b1;
        end
        ST_A2: begin
          acc_q <= a2;
          if (over_cap(a2)) fault_q <= 1'b1;
        end
        ST_A3: begin
          if (fin > VMAX_X || fin < VMIN_X) fault_q <= 1'b1;
          u_q[ax] <= fin[W-1:0];
          ppt[ax] <= cur_tp;
          pvt[ax] <= vs_q;
          ax      <= ax + 2'd1;
        end
        ST_DONE: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= fault_q ? '0 : MD_W'({u_q[2], u_q[1], u_q[0]});
            m_tuser[0] <= fault_q;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
